// ----- sv/spll_pkg.sv -----
// Shared types and constants for the slot pool linked list.
// Holds pool sizing, request and status codes, controller states and the
// command and status bundles between controller and datapath. No dependencies.
package spll_pkg;

	localparam int POOL_SLOTS = 32;
	localparam int TAG_BITS   = 32;
	localparam int SLOT_W     = $clog2(POOL_SLOTS);
	localparam int LINK_W     = SLOT_W + 1;
	localparam int CNT_W      = $clog2(POOL_SLOTS + 1);

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_SLOTS);
	localparam logic [CNT_W-1:0]  POOL_FULL = CNT_W'(POOL_SLOTS);

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_LINK,
		S_FIX,
		S_OUT
	} ctrl_state_t;

	typedef struct packed {
		logic    load_req;
		logic    find_free;
		logic    unlink;
		logic    link_new;
		logic    link_head;
		logic    set_status;
		status_t status_code;
		logic    emit;
	} cmd_t;

	typedef struct packed {
		logic is_remove;
		logic pool_full;
		logic slot_busy;
		logic out_busy;
	} dp_stat_t;

endpackage

// ----- sv/spll_ctrl.sv -----
// Controller state machine for the slot pool linked list.
// Sequences each request through look-up, linking and result hand-off.
// Depends on spll_pkg.
module spll_ctrl
	import spll_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dp_stat_t stat,
	output cmd_t     cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_nxt = S_LOOK;
				end
			end
			S_LOOK: begin
				if (stat.is_remove || stat.pool_full) begin
					state_nxt = S_OUT;
				end else begin
					state_nxt = S_LINK;
				end
			end
			S_LINK: state_nxt = S_FIX;
			S_FIX:  state_nxt = S_OUT;
			S_OUT: begin
				if (!stat.out_busy) begin
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_req = in_valid;
			end
			S_LOOK: begin
				if (stat.is_remove) begin
					cmd.set_status = 1'b1;
					if (stat.slot_busy) begin
						cmd.unlink      = 1'b1;
						cmd.status_code = ST_OK;
					end else begin
						cmd.status_code = ST_EMPTY;
					end
				end else if (stat.pool_full) begin
					cmd.set_status  = 1'b1;
					cmd.status_code = ST_FULL;
				end else begin
					cmd.find_free = 1'b1;
				end
			end
			S_LINK: cmd.link_new = 1'b1;
			S_FIX: begin
				cmd.link_head   = 1'b1;
				cmd.set_status  = 1'b1;
				cmd.status_code = ST_OK;
			end
			S_OUT: cmd.emit = !stat.out_busy;
			default: cmd = '0;
		endcase
	end

endmodule

// ----- sv/spll_dp.sv -----
// Datapath for the slot pool linked list: occupancy bits, tag and link
// memories, head, cursor and count registers, free-slot search and the
// result register. Depends on spll_pkg; driven by commands from spll_ctrl.
module spll_dp
	import spll_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output dp_stat_t            stat,
	input  logic                req_type,
	input  logic [TAG_BITS-1:0] entry_tag,
	input  logic [SLOT_W-1:0]   slot_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [SLOT_W-1:0]   given_slot,
	output logic [SLOT_W-1:0]   head_slot,
	output logic                list_empty,
	output logic [CNT_W-1:0]    occupied_count
);

	logic [TAG_BITS-1:0] tag_mem  [POOL_SLOTS];
	logic [LINK_W-1:0]   next_mem [POOL_SLOTS];
	logic [LINK_W-1:0]   prev_mem [POOL_SLOTS];

	logic [POOL_SLOTS-1:0] used_q;
	logic [LINK_W-1:0]     head_q;
	logic [SLOT_W-1:0]     cursor_q;
	logic [CNT_W-1:0]      count_q;
	logic                  out_valid_q;

	logic                req_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [SLOT_W-1:0]   idx_q;
	logic [SLOT_W-1:0]   pos_q;
	logic [LINK_W-1:0]   next_rd_q;
	logic [LINK_W-1:0]   prev_rd_q;
	status_t             status_q;
	logic [SLOT_W-1:0]   given_q;

	status_t           out_status_q;
	logic [SLOT_W-1:0] out_given_q;
	logic [SLOT_W-1:0] out_head_q;
	logic              out_empty_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [2*POOL_SLOTS-1:0] free_dbl;
	logic [POOL_SLOTS-1:0]   free_rot;
	logic [SLOT_W-1:0]       free_off;
	logic [SLOT_W-1:0]       free_pos;

	logic              next_we;
	logic [SLOT_W-1:0] next_wa;
	logic [LINK_W-1:0] next_wd;
	logic              prev_we;
	logic [SLOT_W-1:0] prev_wa;
	logic [LINK_W-1:0] prev_wd;
	logic              head_null;

	assign head_null = (head_q == NULL_LINK);

	assign stat.is_remove = (req_q == REQ_REMOVE);
	assign stat.pool_full = (count_q == POOL_FULL);
	assign stat.slot_busy = used_q[idx_q];
	assign stat.out_busy  = out_valid_q && !out_ready;

	// The search looks at the free slots rotated so that the cursor sits at bit zero.
	assign free_dbl = {~used_q, ~used_q};
	assign free_rot = free_dbl[cursor_q +: POOL_SLOTS];

	always_comb begin
		free_off = '0;
		for (int i = POOL_SLOTS - 1; i >= 0; i--) begin
			if (free_rot[i]) begin
				free_off = SLOT_W'(i);
			end
		end
	end

	assign free_pos = cursor_q + free_off;

	always_comb begin
		next_we = 1'b0;
		next_wa = pos_q;
		next_wd = head_q;
		prev_we = 1'b0;
		prev_wa = pos_q;
		prev_wd = NULL_LINK;
		if (cmd.unlink) begin
			next_we = (prev_rd_q != NULL_LINK);
			next_wa = prev_rd_q[SLOT_W-1:0];
			next_wd = next_rd_q;
			prev_we = (next_rd_q != NULL_LINK);
			prev_wa = next_rd_q[SLOT_W-1:0];
			prev_wd = prev_rd_q;
		end else if (cmd.link_new) begin
			next_we = 1'b1;
			prev_we = 1'b1;
		end else if (cmd.link_head) begin
			prev_we = !head_null;
			prev_wa = head_q[SLOT_W-1:0];
			prev_wd = {1'b0, pos_q};
		end
	end

	always_ff @(posedge clk) begin
		if (next_we) begin
			next_mem[next_wa] <= next_wd;
		end
		if (prev_we) begin
			prev_mem[prev_wa] <= prev_wd;
		end
		if (cmd.link_new) begin
			tag_mem[pos_q] <= tag_q;
		end
		if (cmd.load_req) begin
			next_rd_q <= next_mem[slot_index];
			prev_rd_q <= prev_mem[slot_index];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			head_q      <= NULL_LINK;
			cursor_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.unlink) begin
				used_q[idx_q] <= 1'b0;
				count_q       <= count_q - 1'b1;
				cursor_q      <= idx_q;
				if (prev_rd_q == NULL_LINK) begin
					head_q <= next_rd_q;
				end
			end
			if (cmd.link_new) begin
				used_q[pos_q] <= 1'b1;
				count_q       <= count_q + 1'b1;
				cursor_q      <= pos_q;
			end
			if (cmd.link_head) begin
				head_q <= {1'b0, pos_q};
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			req_q <= req_type;
			tag_q <= entry_tag;
			idx_q <= slot_index;
		end
		if (cmd.find_free) begin
			pos_q <= free_pos;
		end
		if (cmd.set_status) begin
			status_q <= cmd.status_code;
			if (cmd.status_code == ST_FULL) begin
				given_q <= '0;
			end else if (req_q == REQ_REMOVE) begin
				given_q <= idx_q;
			end else begin
				given_q <= pos_q;
			end
		end
		if (cmd.emit) begin
			out_status_q <= status_q;
			out_given_q  <= given_q;
			out_head_q   <= head_null ? '0 : head_q[SLOT_W-1:0];
			out_empty_q  <= head_null;
			out_count_q  <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign given_slot     = out_given_q;
	assign head_slot      = out_head_q;
	assign list_empty     = out_empty_q;
	assign occupied_count = out_count_q;

endmodule

// ----- sv/slot_pool_linked_list_top.sv -----
// Top level of the slot pool linked list: a 32-slot tag pool whose occupied
// slots form a doubly linked list. Depends on spll_pkg, spll_ctrl and spll_dp.
//
//   Channel  Signals               Beat
//   in       in_valid, in_ready    req_type, entry_tag, slot_index
//   out      out_valid, out_ready  status, given_slot, head_slot, list_empty, occupied_count
//
// An insert runs through search, slot write, head link and hand-off after acceptance, and a
// remove or refusal goes from look-up to hand-off, and idle comes before the next beat.
// One write port per link memory splits an insert's linking into slot write and head link.
// Reset clears occupancy, head, cursor and count at once; there is no clearing pass.
// A new request is taken while the previous result still waits in the output register,
// but the block stalls in hand-off while that result is still held there.
module slot_pool_linked_list_top
	import spll_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                req_type,
	input  logic [TAG_BITS-1:0] entry_tag,
	input  logic [SLOT_W-1:0]   slot_index,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [SLOT_W-1:0]   given_slot,
	output logic [SLOT_W-1:0]   head_slot,
	output logic                list_empty,
	output logic [CNT_W-1:0]    occupied_count
);

	cmd_t     cmd;
	dp_stat_t stat;

	spll_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	spll_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.req_type       (req_type),
		.entry_tag      (entry_tag),
		.slot_index     (slot_index),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.given_slot     (given_slot),
		.head_slot      (head_slot),
		.list_empty     (list_empty),
		.occupied_count (occupied_count)
	);

endmodule
